/* src/yuyvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB pixel writer package
// Transaction types, register indexes, format codes and color helpers.
// ----------------------------------------------------------------------------
package yuyvrgb_pkg;

  localparam int unsigned DimMaxDefault = 4096;

  localparam int unsigned SizeW    = 13;
  localparam int unsigned OriginW  = 12;
  localparam int unsigned PairsW   = 12;
  localparam int unsigned FormatW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned ColorW   = 32;

  localparam logic [CfgIdxW-1:0] CfgFbWidth     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFbHeight    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginX     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOriginY     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLinePairs   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPixelFormat = 3'd5;

  localparam logic [FormatW-1:0] FmtRgb565   = 2'd0;
  localparam logic [FormatW-1:0] FmtBgr888   = 2'd1;
  localparam logic [FormatW-1:0] FmtArgb8888 = 2'd2;

  localparam logic [SizeW-1:0]   FbWidthReset     = 13'd800;
  localparam logic [SizeW-1:0]   FbHeightReset    = 13'd480;
  localparam logic [PairsW-1:0]  LinePairsReset   = 12'd320;

  localparam logic signed [17:0] CoefRv = 18'sd359;
  localparam logic signed [17:0] CoefGu = 18'sd88;
  localparam logic signed [17:0] CoefGv = 18'sd183;
  localparam logic signed [17:0] CoefBu = 18'sd454;
  localparam logic [7:0]         AlphaOpaque = 8'hFF;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_u;
    logic [7:0] luma_second;
    logic [7:0] chroma_v;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] pixel_index;
    logic [ColorW-1:0] pixel_color;
    logic              write_enable;
    logic              pair_last;
  } out_item_t;

  // floor(num / 256) clamped to 0..255
  function automatic logic [7:0] scale_clamp(logic signed [17:0] num);
    logic signed [9:0] q;
    q = num[17:8];
    if (q < 10'sd0) begin
      return 8'd0;
    end else if (q > 10'sd255) begin
      return 8'hFF;
    end
    return q[7:0];
  endfunction

  function automatic logic [ColorW-1:0] pack_color(logic [FormatW-1:0] fmt,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
    logic [ColorW-1:0] c;
    case (fmt)
      FmtRgb565:   c = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FmtBgr888:   c = {8'h00, r, g, b};
      FmtArgb8888: c = {AlphaOpaque, r, g, b};
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage

/* src/yuyv_to_rgb_pixel_writer.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB pixel writer
// Converts one YUYV group into two packed pixels with framebuffer indexes.
// Timing: the first pixel goes through the group register and then the result
//   register to out_valid_o; the second is loaded as the first is taken.
// Flow: a new group is accepted as the current group's second pixel is loaded,
//   since the single output channel carries two pixels per group.
// Reset: registers return to their defaults, counters and pipeline clear.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_writer #(
  parameter int unsigned DIM_MAX = yuyvrgb_pkg::DimMaxDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  yuyvrgb_pkg::in_item_t            in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output yuyvrgb_pkg::out_item_t           out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [yuyvrgb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [yuyvrgb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CpW    = $clog2(DIM_MAX / 2);
  localparam int unsigned RcW    = $clog2(DIM_MAX);
  localparam int unsigned PosW   = $clog2((2 ** yuyvrgb_pkg::OriginW) + DIM_MAX);
  localparam int unsigned ProdW  = PosW + yuyvrgb_pkg::SizeW;
  localparam int unsigned NextW  = CpW + 1;

  // configuration
  logic [yuyvrgb_pkg::SizeW-1:0]   fb_width_q, fb_height_q;
  logic [yuyvrgb_pkg::OriginW-1:0] origin_x_q, origin_y_q;
  logic [yuyvrgb_pkg::PairsW-1:0]  line_pairs_q;
  logic [yuyvrgb_pkg::FormatW-1:0] pixel_format_q;

  // position counters
  logic [CpW-1:0]   column_pairs_q, column_pairs_d;
  logic [RcW-1:0]   row_count_q, row_count_d;
  logic [NextW-1:0] next_pairs;

  // group register
  logic             grp_valid_q, grp_valid_d;
  logic             sel_q, sel_d;
  logic [7:0]       y0_q, y1_q, u_q, v_q;
  logic [PosW-1:0]  col_q, row_q;

  // result register
  logic                   out_valid_q, out_valid_d;
  yuyvrgb_pkg::out_item_t out_q, pix;

  logic out_ready, load_out, grp_free, in_acc;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign load_out   = grp_valid_q && out_ready;
  assign grp_free   = !grp_valid_q || (load_out && sel_q);
  assign in_stall_o = !grp_free;
  assign in_acc     = in_valid_i && grp_free;

  always_comb begin
    grp_valid_d = grp_valid_q;
    sel_d       = sel_q;
    if (in_acc) begin
      grp_valid_d = 1'b1;
      sel_d       = 1'b0;
    end else if (grp_free) begin
      grp_valid_d = 1'b0;
    end else if (load_out) begin
      sel_d = 1'b1;
    end
    out_valid_d = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
  end

  always_comb begin
    next_pairs     = NextW'(column_pairs_q) + NextW'(1);
    column_pairs_d = column_pairs_q;
    row_count_d    = row_count_q;
    if (in_acc) begin
      if (in_data_i.frame_last) begin
        column_pairs_d = '0;
        row_count_d    = '0;
      end else if (32'(next_pairs) >= 32'(line_pairs_q) ||
                   next_pairs >= NextW'(DIM_MAX / 2)) begin
        column_pairs_d = '0;
        if (row_count_q < RcW'(DIM_MAX - 1)) begin
          row_count_d = row_count_q + RcW'(1);
        end
      end else begin
        column_pairs_d = next_pairs[CpW-1:0];
      end
    end
  end

  // pixel datapath
  logic [7:0]        luma, r, g, b;
  logic signed [7:0] cu, cv;
  logic signed [17:0] ys, cu_x, cv_x;
  logic [PosW-1:0]   col_px;
  logic [ProdW-1:0]  prod;
  logic              in_screen, fmt_ok;

  always_comb begin
    luma   = sel_q ? y1_q : y0_q;
    cu     = signed'({~u_q[7], u_q[6:0]});
    cv     = signed'({~v_q[7], v_q[6:0]});
    ys     = signed'({2'b00, luma, 8'h00});
    cu_x   = 18'(cu);
    cv_x   = 18'(cv);
    r      = yuyvrgb_pkg::scale_clamp(ys + yuyvrgb_pkg::CoefRv * cv_x);
    g      = yuyvrgb_pkg::scale_clamp(ys - yuyvrgb_pkg::CoefGu * cu_x
                                         - yuyvrgb_pkg::CoefGv * cv_x);
    b      = yuyvrgb_pkg::scale_clamp(ys + yuyvrgb_pkg::CoefBu * cu_x);
    col_px = col_q + PosW'(sel_q);
    prod   = ProdW'(row_q) * ProdW'(fb_width_q);
    fmt_ok = pixel_format_q inside {yuyvrgb_pkg::FmtRgb565, yuyvrgb_pkg::FmtBgr888,
                                    yuyvrgb_pkg::FmtArgb8888};
    in_screen = (32'(col_px) < 32'(fb_width_q)) && (32'(row_q) < 32'(fb_height_q)) && fmt_ok;
    pix.pixel_index  = in_screen ? (prod[yuyvrgb_pkg::IndexW-1:0] +
                                    yuyvrgb_pkg::IndexW'(col_px)) : '0;
    pix.pixel_color  = in_screen ? yuyvrgb_pkg::pack_color(pixel_format_q, r, g, b) : '0;
    pix.write_enable = in_screen;
    pix.pair_last    = sel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q     <= yuyvrgb_pkg::FbWidthReset;
      fb_height_q    <= yuyvrgb_pkg::FbHeightReset;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      line_pairs_q   <= yuyvrgb_pkg::LinePairsReset;
      pixel_format_q <= yuyvrgb_pkg::FmtRgb565;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        yuyvrgb_pkg::CfgFbWidth:     fb_width_q     <= cfg_data_i;
        yuyvrgb_pkg::CfgFbHeight:    fb_height_q    <= cfg_data_i;
        yuyvrgb_pkg::CfgOriginX:     origin_x_q     <= cfg_data_i[yuyvrgb_pkg::OriginW-1:0];
        yuyvrgb_pkg::CfgOriginY:     origin_y_q     <= cfg_data_i[yuyvrgb_pkg::OriginW-1:0];
        yuyvrgb_pkg::CfgLinePairs:   line_pairs_q   <= cfg_data_i[yuyvrgb_pkg::PairsW-1:0];
        yuyvrgb_pkg::CfgPixelFormat: pixel_format_q <= cfg_data_i[yuyvrgb_pkg::FormatW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pairs_q <= '0;
      row_count_q    <= '0;
      grp_valid_q    <= 1'b0;
      sel_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      column_pairs_q <= column_pairs_d;
      row_count_q    <= row_count_d;
      grp_valid_q    <= grp_valid_d;
      sel_q          <= sel_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y0_q  <= in_data_i.luma_first;
      y1_q  <= in_data_i.luma_second;
      u_q   <= in_data_i.chroma_u;
      v_q   <= in_data_i.chroma_v;
      col_q <= PosW'(origin_x_q) + PosW'({column_pairs_q, 1'b0});
      row_q <= PosW'(origin_y_q) + PosW'(row_count_q);
    end
    if (load_out) begin
      out_q <= pix;
    end
  end

endmodule
